FILE: rtl/ofm_pkg.sv
`default_nettype none

package ofm_pkg;

    // widths of the word fields as seen on the ports
    localparam int KEY_FIELD_W = 32;
    localparam int COUNT_W     = 5;
    localparam int CAP_W       = 5;

    // default storage shape
    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;

    // capacity register after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // command codes
    typedef enum logic {
        CMD_PUT  = 1'b0,
        CMD_FIND = 1'b1
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/ofm_req_if.sv
`default_nettype none

interface ofm_req_if
    import ofm_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [KEY_FIELD_W-1:0] key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

`default_nettype wire

FILE: rtl/ofm_rsp_if.sv
`default_nettype none

interface ofm_rsp_if
    import ofm_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   evicted_valid;
    logic [KEY_FIELD_W-1:0] evicted_key;
    logic                   found;
    logic [COUNT_W-1:0]     count;
    logic                   is_empty;

    modport source (
        output valid, output evicted_valid, output evicted_key, output found,
        output count, output is_empty, input ready
    );
    modport sink (
        input valid, input evicted_valid, input evicted_key, input found,
        input count, input is_empty, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/overwrite_fifo_with_membership_unit.sv
`default_nettype none

// channel   dir  payload                                          handshake
// req       in   cmd, key                                         valid/ready
// rsp       out  evicted_valid, evicted_key, found, count,        valid/ready
//                is_empty
// cfg       in   cfg_wr_data (capacity)                           cfg_wr_en
//
// a put passes through the put and result states after accept, a find through scan, last
// and result, or straight to result when the history is empty
// a find walks the stored entries through the single memory read port, one per cycle
// one word in flight; req.ready is high in idle even while a result waits on rsp
// a stalled result holds in the output register, the engine parks until it is taken
// rst_n clears head, count, control and capacity (16); the key memory is not cleared

module overwrite_fifo_with_membership_unit
    import ofm_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [CAP_W-1:0] cfg_wr_data,
    ofm_req_if.sink               req,
    ofm_rsp_if.source             rsp
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    // one-hot sequencer
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PUT    = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_LAST   = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    // circular index add: base stays below DEPTH and offs at most DEPTH, so one subtract wraps
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offs);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(offs);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return AW'(sum);
    endfunction

    // control state
    state_t             state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      scan_reg, scan_next;
    logic [CAP_W-1:0]   cap_reg;
    logic               out_valid_reg, out_valid_next;

    // word being worked on
    logic               cmd_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic               found_reg;
    logic               evict_reg;

    // output register payload
    logic               o_evicted_valid_reg;
    logic [KEY_FIELD_W-1:0] o_evicted_key_reg;
    logic               o_found_reg;
    logic [COUNT_W-1:0] o_count_reg;
    logic               o_is_empty_reg;

    // key store, one synchronous read port and one write port
    logic [KEY_WIDTH-1:0] mem [DEPTH];
    logic [KEY_WIDTH-1:0] rdata_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;

    logic accept;
    logic is_full;
    logic out_free;
    logic out_load;
    logic [CMPW-1:0] cap_floor;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign out_load = (state_reg == ST_RESULT) && out_free;

    // zero capacity acts as one; at DEPTH the store is full whatever the register says
    assign cap_floor = (cap_reg == '0) ? CMPW'(1) : CMPW'(cap_reg);
    assign is_full   = (CMPW'(count_reg) >= cap_floor) || (count_reg == CW'(DEPTH));

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        // new key always lands at the tail, also when it overwrites the oldest
        mem_waddr      = wrap_add(head_reg, count_reg);
        mem_raddr      = head_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                scan_next = '0;
                if (accept)
                begin
                    if (req.cmd == CMD_PUT)
                    begin
                        state_next = ST_PUT;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_PUT:
            begin
                // write the key and fetch the oldest in the same cycle;
                // the read sees the old contents if both hit one entry
                mem_we     = 1'b1;
                mem_re     = is_full;
                state_next = ST_RESULT;
                if (is_full)
                begin
                    head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                // issue one read per cycle; the compare works on the registered read data
                mem_re    = 1'b1;
                mem_raddr = wrap_add(head_reg, CW'(scan_reg));
                scan_next = scan_reg + 1'b1;
                if (CW'(scan_reg) == count_reg - CW'(1))
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // per-word payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= req.cmd;
            key_reg   <= KEY_WIDTH'(req.key);
            found_reg <= 1'b0;
            evict_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_PUT)
            begin
                evict_reg <= is_full;
            end
            // rdata holds the entry read in the previous cycle
            if (((state_reg == ST_SCAN) && (scan_reg != '0)) || (state_reg == ST_LAST))
            begin
                if (rdata_reg == key_reg)
                begin
                    found_reg <= 1'b1;
                end
            end
        end

        if (out_load)
        begin
            o_evicted_valid_reg <= (cmd_reg == CMD_PUT) && evict_reg;
            o_evicted_key_reg   <= ((cmd_reg == CMD_PUT) && evict_reg)
                                   ? KEY_FIELD_W'(rdata_reg) : '0;
            o_found_reg         <= (cmd_reg == CMD_FIND) && found_reg;
            o_count_reg         <= COUNT_W'(count_reg);
            o_is_empty_reg      <= (count_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= key_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.evicted_valid = o_evicted_valid_reg;
    assign rsp.evicted_key   = o_evicted_key_reg;
    assign rsp.found         = o_found_reg;
    assign rsp.count         = o_count_reg;
    assign rsp.is_empty      = o_is_empty_reg;

endmodule

`default_nettype wire

FILE: rtl/ofm_checker.sv
`default_nettype none

module ofm_checker
    import ofm_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   req_valid,
    input wire logic                   req_ready,
    input wire logic                   rsp_valid,
    input wire logic                   rsp_ready,
    input wire logic                   rsp_evicted_valid,
    input wire logic [KEY_FIELD_W-1:0] rsp_evicted_key,
    input wire logic                   rsp_found,
    input wire logic [COUNT_W-1:0]     rsp_count,
    input wire logic                   rsp_is_empty
);

    // a result waiting on the sink stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // one word at a time: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second word taken while busy");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_is_empty == (rsp_count == '0)))
        else $error("empty flag disagrees with count");

    // a result with an eviction reports no match and a non-empty store
    a_evict_no_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_evicted_valid |-> !rsp_found && !rsp_is_empty)
        else $error("eviction with found or empty");

    a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_evicted_valid |-> (rsp_evicted_key == '0))
        else $error("evicted key not zero without eviction");

endmodule

bind overwrite_fifo_with_membership_unit ofm_checker u_ofm_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_evicted_valid (rsp.evicted_valid),
    .rsp_evicted_key   (rsp.evicted_key),
    .rsp_found         (rsp.found),
    .rsp_count         (rsp.count),
    .rsp_is_empty      (rsp.is_empty)
);

`default_nettype wire
